>>> rtl/mcssl_pkg.sv
`default_nettype none

package mcssl_pkg;

  // Channel storage never grows past the 4-bit channel field.
  localparam int CHANNELS_DEF = 16;
  localparam int MAX_CH       = 16;

  localparam int CH_W    = 4;
  localparam int ANG_W   = 13;
  localparam int UANG_W  = 12;
  localparam int PULSE_W = 12;
  localparam int MASK_W  = 16;

  // Pulse mapping: 14x14 signed products, a 27-bit signed sum and a
  // 26-bit magnitude for the iterative divider.
  localparam int MUL_W  = 14;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 27;
  localparam int NUM_W  = 26;
  localparam int DEN_W  = 13;
  localparam int CNT_W  = $clog2(NUM_W + 1);

  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 5;
  localparam int REG_LSB = 2;

  localparam logic [PULSE_W-1:0] PULSE_MAX = '1;

  localparam logic                     RST_DRIVER_PRESENT = 1'b1;
  localparam logic [MASK_W-1:0]        RST_POPULATED_MASK = 16'd31;
  localparam logic signed [ANG_W-1:0]  RST_MIN_ANGLE      = -13'sd1440;
  localparam logic [UANG_W-1:0]        RST_MAX_ANGLE      = 12'd1440;
  localparam logic [UANG_W-1:0]        RST_SLEW_STEP      = 12'd32;
  localparam logic [PULSE_W-1:0]       RST_MIN_PULSE      = 12'd1000;
  localparam logic [PULSE_W-1:0]       RST_CENTER_PULSE   = 12'd1500;
  localparam logic [PULSE_W-1:0]       RST_MAX_PULSE      = 12'd2000;

  typedef enum logic [1:0] {
    FUNC_SET    = 2'd0,
    FUNC_TICK   = 2'd1,
    FUNC_CENTER = 2'd2,
    FUNC_READ   = 2'd3
  } func_t;

  typedef enum logic {
    KIND_PULSE = 1'b0,
    KIND_READ  = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    REG_DRIVER_PRESENT = 3'd0,
    REG_POPULATED_MASK = 3'd1,
    REG_MIN_ANGLE      = 3'd2,
    REG_MAX_ANGLE      = 3'd3,
    REG_SLEW_STEP      = 3'd4,
    REG_MIN_PULSE      = 3'd5,
    REG_CENTER_PULSE   = 3'd6,
    REG_MAX_PULSE      = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL1,
    ST_MUL2,
    ST_SUM,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] numer;
    logic [DEN_W-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> rtl/mcssl_if.sv
`default_nettype none

interface mcssl_in_if;
  logic                                       valid;
  logic                                       ready;
  mcssl_pkg::func_t                           func;
  logic [mcssl_pkg::CH_W-1:0]                 channel;
  logic signed [mcssl_pkg::ANG_W-1:0]         angle;

  modport source (output valid, func, channel, angle, input ready);
  modport sink   (input valid, func, channel, angle, output ready);
endinterface

interface mcssl_out_if;
  logic                                       valid;
  logic                                       ready;
  mcssl_pkg::kind_t                           kind;
  logic [mcssl_pkg::CH_W-1:0]                 out_channel;
  logic [mcssl_pkg::PULSE_W-1:0]              pulse_width;
  logic signed [mcssl_pkg::ANG_W-1:0]         current_angle;
  logic                                       last;

  modport source (output valid, kind, out_channel, pulse_width, current_angle, last,
                  input ready);
  modport sink   (input valid, kind, out_channel, pulse_width, current_angle, last,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/mcssl_divider.sv
`default_nettype none

// Restoring divider on magnitudes, one quotient bit per cycle.
module mcssl_divider (
  input  logic                clk,
  input  logic                rst,
  input  mcssl_pkg::div_req_t req,
  output mcssl_pkg::div_rsp_t rsp
);
  import mcssl_pkg::*;

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_diff;
  logic             fits;

  assign rem_sh   = {rem, num[NUM_W-1]};
  assign fits     = rem_sh >= {1'b0, den};
  assign rem_diff = rem_sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The remainder always stays below the divisor, so it fits DEN_W bits.
  always_ff @(posedge clk) begin
    if (req.start) begin
      num <= req.numer;
      den <= req.denom;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      num <= {num[NUM_W-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = num;

endmodule

`default_nettype wire

>>> rtl/multi_channel_servo_slew_limiter_core.sv
// Set and center complete in the accepting cycle; a read reply is
// registered and appears in the cycle after its transaction.
// A tick passes over each idle channel and runs each moving channel through the
// 26-step shared divider, so the length of a tick grows with the moving channels.
// Reset (rst, synchronous, active high) restores the register defaults and
// clears all targets, present angles and moving marks at once.
`default_nettype none

module multi_channel_servo_slew_limiter_core #(
  parameter int CHANNELS = mcssl_pkg::CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  mcssl_in_if.sink                     in_chan,
  mcssl_out_if.source                  out_chan,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mcssl_pkg::ADDR_W-1:0] paddr,
  input  logic [mcssl_pkg::DATA_W-1:0] pwdata,
  output logic [mcssl_pkg::DATA_W-1:0] prdata,
  output logic                         pready
);
  import mcssl_pkg::*;

  // Only the first sixteen channels can be addressed, so storage stops there.
  localparam int NCH   = (CHANNELS < MAX_CH) ? CHANNELS : MAX_CH;
  localparam int IDX_W = (NCH > 1) ? $clog2(NCH) : 1;
  localparam logic [CH_W:0]    CH_LIM   = (CH_W + 1)'(NCH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NCH - 1);

  // ---------------------------------------------------------------------
  // Configuration registers. The write lands on the access phase; pready is
  // tied high so every access completes without wait states.
  // ---------------------------------------------------------------------
  logic                      driver_present;
  logic [MASK_W-1:0]         populated_mask;
  logic signed [ANG_W-1:0]   min_angle;
  logic [UANG_W-1:0]         max_angle;
  logic [UANG_W-1:0]         slew_step;
  logic [PULSE_W-1:0]        min_pulse;
  logic [PULSE_W-1:0]        center_pulse;
  logic [PULSE_W-1:0]        max_pulse;

  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:REG_LSB]);

  always_ff @(posedge clk) begin
    if (rst) begin
      driver_present <= RST_DRIVER_PRESENT;
      populated_mask <= RST_POPULATED_MASK;
      min_angle      <= RST_MIN_ANGLE;
      max_angle      <= RST_MAX_ANGLE;
      slew_step      <= RST_SLEW_STEP;
      min_pulse      <= RST_MIN_PULSE;
      center_pulse   <= RST_CENTER_PULSE;
      max_pulse      <= RST_MAX_PULSE;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_DRIVER_PRESENT: driver_present <= pwdata[0];
        REG_POPULATED_MASK: populated_mask <= pwdata[MASK_W-1:0];
        REG_MIN_ANGLE:      min_angle      <= $signed(pwdata[ANG_W-1:0]);
        REG_MAX_ANGLE:      max_angle      <= pwdata[UANG_W-1:0];
        REG_SLEW_STEP:      slew_step      <= pwdata[UANG_W-1:0];
        REG_MIN_PULSE:      min_pulse      <= pwdata[PULSE_W-1:0];
        REG_CENTER_PULSE:   center_pulse   <= pwdata[PULSE_W-1:0];
        REG_MAX_PULSE:      max_pulse      <= pwdata[PULSE_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_DRIVER_PRESENT: prdata = DATA_W'(driver_present);
      REG_POPULATED_MASK: prdata = DATA_W'(populated_mask);
      REG_MIN_ANGLE:      prdata = DATA_W'(unsigned'(min_angle));
      REG_MAX_ANGLE:      prdata = DATA_W'(max_angle);
      REG_SLEW_STEP:      prdata = DATA_W'(slew_step);
      REG_MIN_PULSE:      prdata = DATA_W'(min_pulse);
      REG_CENTER_PULSE:   prdata = DATA_W'(center_pulse);
      REG_MAX_PULSE:      prdata = DATA_W'(max_pulse);
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer state and the items it carries from step to step.
  // ---------------------------------------------------------------------
  state_t state, state_next;

  logic [IDX_W-1:0]        idx;
  logic signed [ANG_W-1:0] ang;      // present angle after this tick's step
  logic signed [ANG_W-1:0] div_d;    // signed divisor of the active half
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0] acc;
  logic [NUM_W-1:0]        quot;
  logic                    neg;

  // Output register; a new result may be loaded while the old one leaves.
  logic                    o_valid;
  kind_t                   o_kind;
  logic [CH_W-1:0]         o_ch;
  logic [PULSE_W-1:0]      o_pulse;
  logic signed [ANG_W-1:0] o_ang;
  logic                    o_last;
  logic                    out_free;

  // Channel state in flip-flops with a single shared read address.
  logic signed [ANG_W-1:0] target  [NCH];
  logic signed [ANG_W-1:0] present [NCH];
  logic [NCH-1:0]          moving;

  // Control strobes from the output decoder.
  logic in_ready;
  logic div_start;
  logic fin_load;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic in_acc;
  logic ch_ok;
  logic [IDX_W-1:0] rd_addr;
  logic signed [ANG_W-1:0] t_rd;
  logic signed [ANG_W-1:0] p_rd;

  assign in_acc  = in_chan.valid && in_ready;
  assign ch_ok   = {1'b0, in_chan.channel} < CH_LIM;
  assign out_free = !o_valid || out_chan.ready;

  // While idle the port addresses the channel named by the transaction;
  // during a tick the walking index owns it.
  assign rd_addr = (state == ST_IDLE) ? in_chan.channel[IDX_W-1:0] : idx;
  assign t_rd    = target[rd_addr];
  assign p_rd    = present[rd_addr];

  // Set command: clamp into the configured window, low bound checked first.
  logic signed [ANG_W-1:0] max_s;
  logic signed [ANG_W-1:0] clamped;

  assign max_s = $signed({1'b0, max_angle});

  always_comb begin
    if (in_chan.angle < min_angle) begin
      clamped = min_angle;
    end else if (in_chan.angle > max_s) begin
      clamped = max_s;
    end else begin
      clamped = in_chan.angle;
    end
  end

  // Slew step for the channel under the walking index.
  logic signed [ANG_W:0]   diff;
  logic [ANG_W:0]          mag;
  logic signed [ANG_W:0]   stepped;
  logic                    arrive;
  logic signed [ANG_W-1:0] step_angle;

  assign diff   = {t_rd[ANG_W-1], t_rd} - {p_rd[ANG_W-1], p_rd};
  assign mag    = diff[ANG_W] ? unsigned'(-diff) : unsigned'(diff);
  assign arrive = mag <= {2'b00, slew_step};

  always_comb begin
    if (diff[ANG_W]) begin
      stepped = {p_rd[ANG_W-1], p_rd} - $signed({2'b00, slew_step});
    end else begin
      stepped = {p_rd[ANG_W-1], p_rd} + $signed({2'b00, slew_step});
    end
    // A partial step lies between present and target, so 13 bits hold it.
    step_angle = arrive ? t_rd : stepped[ANG_W-1:0];
  end

  // Pulse mapping for the new angle a:
  //   pulse = (center*d + a*e) / d, truncated toward zero,
  // where d is max_angle and e = max_pulse - center for a >= 0, and d is
  // min_angle and e = min_pulse - center below zero. Both products go
  // through one 14x14 multiplier on successive cycles.
  logic signed [ANG_W-1:0] d_sel;
  logic signed [ANG_W-1:0] e_sel;
  logic signed [MUL_W-1:0] mul_a;
  logic signed [MUL_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_p;

  always_comb begin
    if (!ang[ANG_W-1]) begin
      d_sel = $signed({1'b0, max_angle});
      e_sel = $signed({1'b0, max_pulse}) - $signed({1'b0, center_pulse});
    end else begin
      d_sel = min_angle;
      e_sel = $signed({1'b0, min_pulse}) - $signed({1'b0, center_pulse});
    end
  end

  always_comb begin
    if (state == ST_MUL1) begin
      mul_a = $signed({2'b00, center_pulse});
      mul_b = {d_sel[ANG_W-1], d_sel};
    end else begin
      mul_a = {ang[ANG_W-1], ang};
      mul_b = {e_sel[ANG_W-1], e_sel};
    end
  end

  assign mul_p = mul_a * mul_b;

  // The divider sees magnitudes; the sign of the quotient is kept aside.
  // A divisor of -4096 negates to the same bit pattern, read as unsigned.
  logic [ACC_W-1:0] acc_mag;

  assign acc_mag        = acc[ACC_W-1] ? unsigned'(-acc) : unsigned'(acc);
  assign div_req.start  = div_start;
  assign div_req.numer  = acc_mag[NUM_W-1:0];
  assign div_req.denom  = div_d[ANG_W-1] ? unsigned'(-div_d) : unsigned'(div_d);

  mcssl_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // A negative quotient saturates to zero, a large one to the top code.
  logic [PULSE_W-1:0] pulse_sat;

  always_comb begin
    if (neg) begin
      pulse_sat = '0;
    end else if (quot > NUM_W'(PULSE_MAX)) begin
      pulse_sat = PULSE_MAX;
    end else begin
      pulse_sat = quot[PULSE_W-1:0];
    end
  end

  // The result is the last of the tick when no channel beyond this one is
  // still moving; those marks are untouched until the walk reaches them.
  logic [NCH-1:0] above_mask;
  logic           tick_last;

  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      above_mask[k] = k > int'(idx);
    end
  end

  assign tick_last = ~|(moving & above_mask);

  // ---------------------------------------------------------------------
  // Sequencer: next state.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && (in_chan.func == FUNC_TICK) && driver_present) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (moving[idx]) begin
          state_next = ST_MUL1;
        end else if (idx == IDX_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_MUL1: begin
        // A zero divisor maps the half straight to the center pulse.
        state_next = (d_sel == '0) ? ST_FIN : ST_MUL2;
      end
      ST_MUL2:      state_next = ST_SUM;
      ST_SUM:       state_next = ST_DIV_START;
      ST_DIV_START: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = (idx == IDX_LAST) ? ST_IDLE : ST_SCAN;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer: control outputs.
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    fin_load  = 1'b0;
    unique case (state)
      ST_IDLE:      in_ready  = !o_valid;
      ST_DIV_START: div_start = 1'b1;
      ST_FIN:       fin_load  = out_free;
      default: begin
        in_ready  = 1'b0;
      end
    endcase
  end

  assign in_chan.ready = in_ready;

  // ---------------------------------------------------------------------
  // Channel state updates.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NCH; i++) begin
        target[i]  <= '0;
        present[i] <= '0;
      end
      moving <= '0;
    end else begin
      if (in_acc && (in_chan.func == FUNC_SET) && ch_ok) begin
        target[in_chan.channel[IDX_W-1:0]] <= clamped;
        moving[in_chan.channel[IDX_W-1:0]] <= 1'b1;
      end
      if (in_acc && (in_chan.func == FUNC_CENTER)) begin
        for (int i = 0; i < NCH; i++) begin
          if (populated_mask[i]) begin
            target[i]  <= '0;
            present[i] <= '0;
            moving[i]  <= 1'b1;
          end
        end
      end
      if ((state == ST_SCAN) && moving[idx]) begin
        present[idx] <= step_angle;
        if (arrive) begin
          moving[idx] <= 1'b0;
        end
      end
    end
  end

  // Walking index.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (state == ST_IDLE) begin
      idx <= '0;
    end else if ((state == ST_SCAN) && !moving[idx] && (idx != IDX_LAST)) begin
      idx <= idx + 1'b1;
    end else if (fin_load && (idx != IDX_LAST)) begin
      idx <= idx + 1'b1;
    end
  end

  // Mapping datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_SCAN: begin
        ang <= step_angle;
      end
      ST_MUL1: begin
        prod  <= mul_p;
        div_d <= d_sel;
        quot  <= NUM_W'(center_pulse);
        neg   <= 1'b0;
      end
      ST_MUL2: begin
        acc  <= ACC_W'(prod);
        prod <= mul_p;
      end
      ST_SUM: begin
        acc <= acc + ACC_W'(prod);
      end
      ST_DIV_START: begin
        neg <= acc[ACC_W-1] ^ div_d[ANG_W-1];
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          quot <= div_rsp.quot;
        end
      end
      default: begin
        neg <= neg;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------
  logic rd_load;

  assign rd_load = in_acc && (in_chan.func == FUNC_READ);

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (rd_load || fin_load) begin
      o_valid <= 1'b1;
    end else if (out_chan.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_load) begin
      o_kind  <= KIND_READ;
      o_ch    <= in_chan.channel;
      o_pulse <= '0;
      o_ang   <= ch_ok ? p_rd : '0;
      o_last  <= 1'b1;
    end else if (fin_load) begin
      o_kind  <= KIND_PULSE;
      o_ch    <= CH_W'(idx);
      o_pulse <= pulse_sat;
      o_ang   <= ang;
      o_last  <= tick_last;
    end
  end

  assign out_chan.valid         = o_valid;
  assign out_chan.kind          = o_kind;
  assign out_chan.out_channel   = o_ch;
  assign out_chan.pulse_width   = o_pulse;
  assign out_chan.current_angle = o_ang;
  assign out_chan.last          = o_last;

endmodule

`default_nettype wire
